// File: design/sorted_key_amount_table_assert.svh
// Assertion macros used by the sorted key/amount table top module.
`ifndef SORTED_KEY_AMOUNT_TABLE_ASSERT_SVH
`define SORTED_KEY_AMOUNT_TABLE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define SKAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define SKAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/skat_pkg.sv
// Types and constants shared by the sorted key/amount table modules.
`timescale 1ns / 1ps
`default_nettype none
package skat_pkg;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned AMT_W   = 31;
  localparam int unsigned HELD_W  = 7;
  localparam int unsigned ENTRY_W = KEY_W + AMT_W;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_ADD    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_TOP,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    WD_RDATA,
    WD_NEW,
    WD_SUM
  } wr_sel_e;

  typedef enum logic [1:0] {
    WA_PTR,
    WA_PTR_INC,
    WA_PTR_DEC,
    WA_ZERO
  } wa_sel_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_RDATA,
    RES_HELD
  } res_sel_e;

  typedef struct packed {
    logic     latch;
    ptr_op_e  ptr_op;
    logic     wr_en;
    wr_sel_e  wr_sel;
    wa_sel_e  wa_sel;
    logic     cap_found;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     finish;
    status_e  res_status;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    key_zero;
    logic    full;
    logic    empty;
    logic    key_eq;
    logic    key_gt;
    logic    ptr_zero;
    logic    ptr_last;
  } stat_t;

endpackage
`default_nettype wire

// File: design/sorted_key_amount_table.sv
// Sorted key/amount table: a rejected, full or empty-table item is finished straight from
// the check state; otherwise the search or shift may walk the whole table. One table
// entry is read per cycle from the single-read-port table memory; the search and shift
// both walk it one entry a cycle. A new item is taken in the cycle of the result strobe.
// The receiver cannot stall. Reset is asynchronous, active low, and empties the table;
// memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_amount_table_assert.svh"
module sorted_key_amount_table
  import skat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        action_i,
  input  wire logic [KEY_W-1:0]  key_i,
  input  wire logic [AMT_W-1:0]  amount_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [KEY_W-1:0]       found_key_o,
  output logic [AMT_W-1:0]       found_amount_o,
  output logic [HELD_W-1:0]      entries_held_o
);

  cmd_t  cmd;
  stat_t stat;

  skat_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  skat_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (action_i),
    .key_i          (key_i),
    .amount_i       (amount_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .found_key_o    (found_key_o),
    .found_amount_o (found_amount_o),
    .entries_held_o (entries_held_o)
  );

  `SKAT_ASSERT_IMP(a_done_idle, done_o, !busy, "result strobe while busy")
  `SKAT_ASSERT_NXT(a_start_busy, start && !busy, busy && !done_o, "transfer not taken")
  `SKAT_ASSERT_IMP(a_miss_zero, done_o && (status_o != ST_DONE),
                   (found_key_o == '0) && (found_amount_o == '0), "found fields on miss")
  `SKAT_ASSERT_IMP(a_full_count, done_o && (status_o == ST_FULL),
                   entries_held_o == HELD_W'(TABLE_DEPTH), "full with wrong count")

endmodule
`default_nettype wire

// File: design/skat_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module skat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: design/skat_ctrl.sv
// Controller state machine: sequences search, shift and result for each item.
`timescale 1ns / 1ps
`default_nettype none
module skat_ctrl
  import skat_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  output logic       busy,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INS,
    S_INS_LAST,
    S_SCAN,
    S_SHIFT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.ptr_op     = PTR_HOLD;
    cmd_o.wr_sel     = WD_RDATA;
    cmd_o.wa_sel     = WA_PTR;
    cmd_o.res_status = ST_DONE;
    cmd_o.res_sel    = RES_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.key_zero) begin
          cmd_o.finish     = 1'b1;
          cmd_o.res_status = ST_REJECT;
          state_d          = S_IDLE;
        end else if (stat_i.action == ACT_INSERT) begin
          if (stat_i.full) begin
            cmd_o.finish     = 1'b1;
            cmd_o.res_status = ST_FULL;
            state_d          = S_IDLE;
          end else if (stat_i.empty) begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_sel  = WD_NEW;
            cmd_o.wa_sel  = WA_ZERO;
            cmd_o.cnt_inc = 1'b1;
            cmd_o.finish  = 1'b1;
            state_d       = S_IDLE;
          end else begin
            // walk down from the last entry, shifting larger keys up
            cmd_o.ptr_op = PTR_TOP;
            state_d      = S_INS;
          end
        end else if (stat_i.empty) begin
          cmd_o.finish     = 1'b1;
          cmd_o.res_status = ST_REJECT;
          state_d          = S_IDLE;
        end else begin
          cmd_o.ptr_op = PTR_ZERO;
          state_d      = S_SCAN;
        end
      end
      S_INS: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = WA_PTR_INC;
        if (stat_i.key_gt) begin
          cmd_o.wr_sel = WD_RDATA;
          if (stat_i.ptr_zero) begin
            state_d = S_INS_LAST;
          end else begin
            cmd_o.ptr_op = PTR_DEC;
          end
        end else begin
          cmd_o.wr_sel  = WD_NEW;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.finish  = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_INS_LAST: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WD_NEW;
        cmd_o.wa_sel  = WA_ZERO;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.finish  = 1'b1;
        state_d       = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.key_eq) begin
          case (stat_i.action)
            ACT_LOOKUP: begin
              cmd_o.finish  = 1'b1;
              cmd_o.res_sel = RES_RDATA;
              state_d       = S_IDLE;
            end
            ACT_ADD: begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = WD_SUM;
              cmd_o.wa_sel = WA_PTR;
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end
            ACT_REMOVE: begin
              if (stat_i.ptr_last) begin
                cmd_o.cnt_dec = 1'b1;
                cmd_o.finish  = 1'b1;
                cmd_o.res_sel = RES_RDATA;
                state_d       = S_IDLE;
              end else begin
                cmd_o.cap_found = 1'b1;
                cmd_o.ptr_op    = PTR_INC;
                state_d         = S_SHIFT;
              end
            end
            default: begin
              // insert never reaches the scan
              state_d = S_IDLE;
            end
          endcase
        end else if (stat_i.key_gt || stat_i.ptr_last) begin
          // sorted order: nothing further can match
          cmd_o.finish     = 1'b1;
          cmd_o.res_status = ST_REJECT;
          state_d          = S_IDLE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end
      S_SHIFT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WD_RDATA;
        cmd_o.wa_sel = WA_PTR_DEC;
        if (stat_i.ptr_last) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.finish  = 1'b1;
          cmd_o.res_sel = RES_HELD;
          state_d       = S_IDLE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// File: design/skat_dp.sv
// Datapath: request registers, table memory, pointer, count and result registers.
`timescale 1ns / 1ps
`default_nettype none
module skat_dp
  import skat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output stat_t                   stat_o,
  input  wire logic [1:0]         action_i,
  input  wire logic [KEY_W-1:0]   key_i,
  input  wire logic [AMT_W-1:0]   amount_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [KEY_W-1:0]        found_key_o,
  output logic [AMT_W-1:0]        found_amount_o,
  output logic [HELD_W-1:0]       entries_held_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // request
  action_e          action_q;
  logic [KEY_W-1:0] key_q;
  logic [AMT_W-1:0] amt_q;

  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [ENTRY_W-1:0] rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [AMT_W-1:0]   rd_amt;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [AMT_W:0]     sum;
  logic [AMT_W-1:0]   sum_sat;

  logic [KEY_W-1:0]   fkey_q;
  logic [AMT_W-1:0]   famt_q;

  logic               done_q;
  logic [1:0]         status_q;
  logic [KEY_W-1:0]   res_key_q;
  logic [AMT_W-1:0]   res_amt_q;
  logic [HELD_W-1:0]  held_q;
  logic [CW+HELD_W-1:0] cnt_ext;

  assign rd_key  = rdata[ENTRY_W-1:AMT_W];
  assign rd_amt  = rdata[AMT_W-1:0];
  assign sum     = {1'b0, rd_amt} + {1'b0, amt_q};
  assign sum_sat = sum[AMT_W] ? {AMT_W{1'b1}} : sum[AMT_W-1:0];

  always_comb begin
    case (cmd_i.ptr_op)
      PTR_ZERO: ptr_d = '0;
      PTR_TOP:  ptr_d = AW'(cnt_q - CW'(1));
      PTR_INC:  ptr_d = ptr_q + AW'(1);
      PTR_DEC:  ptr_d = ptr_q - AW'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wa_sel)
      WA_PTR_INC: waddr = ptr_q + AW'(1);
      WA_PTR_DEC: waddr = ptr_q - AW'(1);
      WA_ZERO:    waddr = '0;
      default:    waddr = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WD_NEW:  wdata = {key_q, amt_q};
      WD_SUM:  wdata = {rd_key, sum_sat};
      default: wdata = rdata;
    endcase
  end

  assign we = cmd_i.wr_en;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  // low bits of the count, zero-extended when the count is narrow
  assign cnt_ext = {{HELD_W{1'b0}}, cnt_d};

  // read address is the next pointer value, so the registered rdata matches ptr_q
  skat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_d),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q <= action_e'(action_i);
      key_q    <= key_i;
      amt_q    <= amount_i;
    end
    if (cmd_i.cap_found) begin
      fkey_q <= rd_key;
      famt_q <= rd_amt;
    end
    if (cmd_i.finish) begin
      status_q <= cmd_i.res_status;
      held_q   <= cnt_ext[HELD_W-1:0];
      case (cmd_i.res_sel)
        RES_RDATA: begin
          res_key_q <= rd_key;
          res_amt_q <= rd_amt;
        end
        RES_HELD: begin
          res_key_q <= fkey_q;
          res_amt_q <= famt_q;
        end
        default: begin
          res_key_q <= '0;
          res_amt_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      cnt_q  <= cnt_d;
      done_q <= cmd_i.finish;
    end
  end

  assign stat_o.action   = action_q;
  assign stat_o.key_zero = (key_q == '0);
  assign stat_o.full     = (cnt_q == CW'(TABLE_DEPTH));
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.key_eq   = (rd_key == key_q);
  assign stat_o.key_gt   = (rd_key > key_q);
  assign stat_o.ptr_zero = (ptr_q == '0);
  assign stat_o.ptr_last = (CW'(ptr_q) == (cnt_q - CW'(1)));

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign found_key_o    = res_key_q;
  assign found_amount_o = res_amt_q;
  assign entries_held_o = held_q;

endmodule
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the sorted key/amount table.
`timescale 1ns / 1ps
module tb;
  import skat_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 2000;
  localparam logic [AMT_W-1:0] AMT_MAX = '1;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef struct packed {
    status_e             status;
    logic [KEY_W-1:0]    found_key;
    logic [AMT_W-1:0]    found_amount;
    logic [HELD_W-1:0]   held;
  } table_result_t;

  logic              clk_i;
  logic              rst_ni   = 1'b0;
  logic              start    = 1'b0;
  logic [1:0]        action_i = '0;
  logic [KEY_W-1:0]  key_i    = '0;
  logic [AMT_W-1:0]  amount_i = '0;
  logic              busy;
  logic              done_o;
  logic [1:0]        status_o;
  logic [KEY_W-1:0]  found_key_o;
  logic [AMT_W-1:0]  found_amount_o;
  logic [HELD_W-1:0] entries_held_o;

  // mirror of the table contents
  logic [KEY_W-1:0] tbl_keys [TABLE_DEPTH];
  logic [AMT_W-1:0] tbl_amounts [TABLE_DEPTH];
  int               held_count = 0;

  table_result_t    pending_results [$];
  int               error_count = 0;
  int               stall_cycles = 0;
  int               gap_mode = 0;
  logic [KEY_W-1:0] key_pool [12];

  sorted_key_amount_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .key_i         (key_i),
    .amount_i      (amount_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_key_o   (found_key_o),
    .found_amount_o(found_amount_o),
    .entries_held_o(entries_held_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic table_result_t apply_table_op(action_e act, logic [KEY_W-1:0] key,
                                                   logic [AMT_W-1:0] amt);
    table_result_t r;
    int            pos;
    logic [AMT_W:0] sum;
    r.status       = ST_REJECT;
    r.found_key    = '0;
    r.found_amount = '0;
    if (key != '0) begin
      if (act == ACT_INSERT) begin
        if (held_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // place after every entry with a key not above the new one
          pos = 0;
          while (pos < held_count && tbl_keys[pos] <= key) pos++;
          for (int i = held_count; i > pos; i--) begin
            tbl_keys[i]    = tbl_keys[i-1];
            tbl_amounts[i] = tbl_amounts[i-1];
          end
          tbl_keys[pos]    = key;
          tbl_amounts[pos] = amt;
          held_count++;
          r.status = ST_DONE;
        end
      end else begin
        pos = held_count;
        for (int i = held_count - 1; i >= 0; i--) begin
          if (tbl_keys[i] == key) pos = i;
        end
        if (pos < held_count) begin
          r.status = ST_DONE;
          if (act == ACT_REMOVE) begin
            r.found_key    = tbl_keys[pos];
            r.found_amount = tbl_amounts[pos];
            for (int i = pos; i + 1 < held_count; i++) begin
              tbl_keys[i]    = tbl_keys[i+1];
              tbl_amounts[i] = tbl_amounts[i+1];
            end
            held_count--;
          end else if (act == ACT_LOOKUP) begin
            r.found_key    = tbl_keys[pos];
            r.found_amount = tbl_amounts[pos];
          end else begin
            sum = {1'b0, tbl_amounts[pos]} + {1'b0, amt};
            tbl_amounts[pos] = sum[AMT_W] ? AMT_MAX : sum[AMT_W-1:0];
          end
        end
      end
    end
    r.held = HELD_W'(held_count);
    return r;
  endfunction

  // Idle the request side for a random gap after a transfer, as gap_mode selects; mode 0 never idles.
  task automatic pause_sender();
    int gap;
    gap = 0;
    if (gap_mode == 1) begin
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(1, 3);
    end else if (gap_mode == 2) begin
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(8, 40);
      else gap = $urandom_range(0, 3);
    end
    if (gap > 0) begin
      start    <= 1'b0;
      action_i <= 2'($urandom);
      key_i    <= KEY_W'($urandom);
      amount_i <= AMT_W'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_op(action_e act, logic [KEY_W-1:0] key, logic [AMT_W-1:0] amt);
    action_i <= act;
    key_i    <= key;
    amount_i <= amt;
    start    <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(apply_table_op(act, key, amt));
    pause_sender();
  endtask

  function automatic logic [AMT_W-1:0] random_amount();
    case ($urandom_range(0, 4))
      0:       return AMT_W'($urandom_range(0, 255));
      1:       return AMT_MAX - AMT_W'($urandom_range(0, 1000));
      default: return AMT_W'($urandom);
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 10) return KEY_W'($urandom);
    if (pick < 35 && held_count > 0) return tbl_keys[$urandom_range(0, held_count - 1)];
    return key_pool[$urandom_range(0, 11)];
  endfunction

  task automatic test_directed_cases();
    gap_mode = 1;
    send_op(ACT_LOOKUP, 31'd5, 31'd0);
    send_op(ACT_REMOVE, 31'd5, 31'd0);
    send_op(ACT_ADD,    31'd5, 31'd9);
    // zero key is refused for every action
    send_op(ACT_INSERT, 31'd0, 31'd1);
    send_op(ACT_REMOVE, 31'd0, 31'd0);
    send_op(ACT_LOOKUP, 31'd0, 31'd0);
    send_op(ACT_ADD,    31'd0, 31'd1);
    send_op(ACT_INSERT, KEY_MAX, AMT_MAX);
    send_op(ACT_INSERT, 31'd1, 31'd0);
    // equal keys keep arrival order
    send_op(ACT_INSERT, 31'd100, 31'd10);
    send_op(ACT_INSERT, 31'd100, 31'd20);
    send_op(ACT_INSERT, 31'd100, 31'd30);
    send_op(ACT_LOOKUP, 31'd100, 31'd0);
    send_op(ACT_REMOVE, 31'd100, 31'd0);
    send_op(ACT_LOOKUP, 31'd100, 31'd0);
    send_op(ACT_ADD,    31'd100, 31'd5);
    send_op(ACT_LOOKUP, 31'd100, 31'd0);
    // saturating and exact-max sums
    send_op(ACT_ADD,    KEY_MAX, AMT_MAX);
    send_op(ACT_LOOKUP, KEY_MAX, 31'd0);
    send_op(ACT_ADD,    31'd1, AMT_MAX);
    send_op(ACT_LOOKUP, 31'd1, 31'd0);
    send_op(ACT_LOOKUP, 31'd50, 31'd0);
    send_op(ACT_REMOVE, 31'd7, 31'd0);
    send_op(ACT_ADD,    31'd7, 31'd3);
    send_op(ACT_INSERT, 31'h2AAAAAAA, 31'h55555555);
    send_op(ACT_INSERT, 31'h55555555, 31'h2AAAAAAA);
  endtask

  task automatic test_full_table();
    gap_mode = 0;
    while (held_count < TABLE_DEPTH) begin
      send_op(ACT_INSERT, KEY_W'($urandom_range(1, 20)), random_amount());
    end
    gap_mode = 2;
    repeat (3) send_op(ACT_INSERT, KEY_W'($urandom_range(1, 40)), random_amount());
    send_op(ACT_INSERT, 31'd0, random_amount());
    send_op(ACT_INSERT, KEY_MAX, AMT_MAX);
    send_op(ACT_LOOKUP, tbl_keys[TABLE_DEPTH-1], 31'd0);
    send_op(ACT_ADD, tbl_keys[0], random_amount());
    // drain by removing entries that are known to be present
    gap_mode = 1;
    while (held_count > 0) begin
      if ($urandom_range(0, 4) == 0)
        send_op(ACT_LOOKUP, tbl_keys[$urandom_range(0, held_count - 1)], 31'd0);
      send_op(ACT_REMOVE, tbl_keys[$urandom_range(0, held_count - 1)], 31'd0);
    end
    send_op(ACT_REMOVE, 31'd3, 31'd0);
  endtask

  task automatic test_random_mix();
    int insert_pct;
    int pick;
    for (int phase = 0; phase < 26; phase++) begin
      gap_mode   = $urandom_range(0, 2);
      insert_pct = $urandom_range(20, 70);
      foreach (key_pool[i]) begin
        key_pool[i] = ($urandom_range(0, 2) == 0) ? KEY_W'($urandom)
                                                  : KEY_W'($urandom_range(1, 30));
      end
      repeat (50) begin
        pick = $urandom_range(0, 99);
        if (pick < insert_pct)
          send_op(ACT_INSERT, random_key(), random_amount());
        else
          send_op(action_e'($urandom_range(1, 3)), random_key(), random_amount());
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    table_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no transfer pending: status %0d key %0h amount %0h",
                 $time, status_o, found_key_o, found_amount_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
        end
        if (found_key_o !== want.found_key) begin
          error_count++;
          $display("%0t: found_key expected %0h actual %0h", $time, want.found_key,
                   found_key_o);
        end
        if (found_amount_o !== want.found_amount) begin
          error_count++;
          $display("%0t: found_amount expected %0h actual %0h", $time, want.found_amount,
                   found_amount_o);
        end
        if (entries_held_o !== want.held) begin
          error_count++;
          $display("%0t: entries_held expected %0d actual %0d", $time, want.held,
                   entries_held_o);
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_full_table();
    test_random_mix();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
